// ----- src/fbpa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

  // Default sizing of the pool
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int WORD_BYTES_DEF = 8;

  // Field widths
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int USED_W     = 16;
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // A valid region offset is below size * count
  localparam int SPAN_W = SIZE_W + COUNT_W;

  localparam int MAX_BLOCK_BYTES = 4096;

  localparam logic [SIZE_W-1:0]  SIZE_CFG_RST  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_CFG_RST = COUNT_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/fbpa_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_cfg_if;
  import fbpa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fbpa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_req_if;
  import fbpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

`default_nettype wire

// ----- src/fbpa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   block_address;
  logic [USED_W-1:0]   blocks_in_use;

  modport source (output valid, output status, output block_address,
                  output blocks_in_use, input ready);
  modport sink   (input valid, input status, input block_address,
                  input blocks_in_use, output ready);
endinterface

`default_nettype wire

// ----- src/fixed_block_pool_allocator.sv -----
// Path, accept to result loaded: alloc multiplies then adds; free checks, then
// waits on the shift-subtract divider; init checks, spans, then writes one link
// a cycle; a no-op or a rejected alloc goes straight to completion. One item at
// a time; the next item is taken once the result sits in the output register.
// Reset (synchronous): pool not ready, free list empty, used count zero. The link
// memory is not cleared; init writes every link that the free list can reach.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BYTES = fbpa_pkg::WORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fbpa_cfg_if.sink    cfg,
  fbpa_req_if.sink    req,
  fbpa_rsp_if.source  rsp
);
  import fbpa_pkg::*;

  // Link values run 0..NUM_BLOCKS-1, with NUM_BLOCKS marking the end of the list
  localparam int LinkW  = $clog2(NUM_BLOCKS + 1);
  localparam int IdxW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int MulAW  = (LinkW > COUNT_W) ? LinkW : COUNT_W;
  localparam int ProdW  = MulAW + SIZE_W;
  localparam int AddrXW = ADDR_W + 1;

  localparam logic [LinkW-1:0]  EmptyLink = LinkW'(NUM_BLOCKS);
  localparam logic [SIZE_W-1:0] WordMask  = SIZE_W'(WORD_BYTES - 1);
  localparam bit                WordPow2  = ((WORD_BYTES & (WORD_BYTES - 1)) == 0);
  localparam logic [USED_W-1:0] UsedMax   = '1;
  localparam logic [AddrXW-1:0] AddrTop   = {1'b1, {ADDR_W{1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_INIT_CHK  = 9'b000000010,
    S_INIT_SPAN = 9'b000000100,
    S_INIT_FILL = 9'b000001000,
    S_ALLOC_MUL = 9'b000010000,
    S_ALLOC_ADD = 9'b000100000,
    S_FREE_CHK  = 9'b001000000,
    S_FREE_DIV  = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  size_cfg;
  logic [COUNT_W-1:0] count_cfg;

  // Pool state
  logic [LinkW-1:0]   head;
  logic               pool_ready;
  logic [USED_W-1:0]  used_blocks;
  logic [SIZE_W-1:0]  active_size;
  logic [COUNT_W-1:0] active_count;
  logic [SPAN_W-1:0]  active_span;

  // Item in flight and its result
  logic [ADDR_W-1:0]  req_addr;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [LinkW-1:0]   sweep_idx;

  // Output register
  logic               rsp_valid;
  status_t            rsp_status;
  logic [ADDR_W-1:0]  rsp_addr;
  logic [USED_W-1:0]  rsp_used;

  // Shared multiplier: span at init, block offset at alloc
  logic [MulAW-1:0]   mul_a;
  logic [SIZE_W-1:0]  mul_b;
  logic [ProdW-1:0]   mul_p;
  logic [ProdW-1:0]   prod;

  logic [SIZE_W-1:0]  size_round;
  logic               init_bad;
  logic               span_over;
  logic               alloc_fail;
  logic [ADDR_W-1:0]  free_off;
  logic               free_bad;
  logic [LinkW-1:0]   fill_next;
  logic               fill_last;

  // Link memory
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [LinkW-1:0]   ram_wdata;
  logic [LinkW-1:0]   ram_rdata;

  // Divider
  logic               div_start;
  logic               div_done;
  logic [COUNT_W-1:0] div_quot;
  logic [SPAN_W-1:0]  div_rem;

  // Round the requested size up to a word multiple (power-of-two words only); a
  // size too large to round fails the range check on the unrounded value anyway
  assign size_round = WordPow2 ? ((size_cfg + WordMask) & ~WordMask) : size_cfg;

  assign init_bad = (32'(size_cfg) < 32'(WORD_BYTES))
                 || (32'(size_cfg) > 32'(MAX_BLOCK_BYTES))
                 || (count_cfg == '0)
                 || (32'(count_cfg) > 32'(NUM_BLOCKS));

  assign span_over = ({1'b0, base_address} + AddrXW'(prod)) > AddrTop;

  assign alloc_fail = !pool_ready || (32'(head) >= 32'(NUM_BLOCKS));

  assign free_off = req_addr - base_address;
  assign free_bad = !pool_ready || (req_addr < base_address)
                 || (free_off >= ADDR_W'(active_span));

  assign mul_a = (state == S_INIT_CHK) ? MulAW'(count_cfg) : MulAW'(head);
  assign mul_b = (state == S_INIT_CHK) ? size_round : active_size;
  assign mul_p = mul_a * mul_b;

  // Chain blocks in ascending order, the last one ends the list
  assign fill_last = (32'(sweep_idx) + 32'd1) == 32'(active_count);
  assign fill_next = fill_last ? EmptyLink : LinkW'(sweep_idx + 1'b1);

  assign div_start = (state == S_FREE_CHK) && !free_bad;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_idx[IdxW-1:0];
    ram_wdata = fill_next;
    if (state == S_INIT_FILL) begin
      ram_we = 1'b1;
    end else if ((state == S_FREE_DIV) && div_done && (div_rem == '0)) begin
      // Push the freed block in front of the current head
      ram_we    = 1'b1;
      ram_waddr = IdxW'(div_quot);
      ram_wdata = head;
    end
  end

  // The read port always follows the head, so the successor is ready by alloc
  fbpa_ram #(
    .WIDTH (LinkW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head[IdxW-1:0]),
    .rdata (ram_rdata)
  );

  // Block index and boundary check: offset / size, remainder must be zero
  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (free_off[SPAN_W-1:0]),
    .divisor  (active_size),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base_address <= '0;
      size_cfg     <= SIZE_CFG_RST;
      count_cfg    <= COUNT_CFG_RST;
      head         <= EmptyLink;
      pool_ready   <= 1'b0;
      used_blocks  <= '0;
      active_size  <= '0;
      active_count <= '0;
      active_span  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      // Register writes are taken at any time; the source keeps them to times
      // with no item in flight
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_BASE:  base_address <= cfg.data[ADDR_W-1:0];
          REG_SIZE:  size_cfg     <= cfg.data[SIZE_W-1:0];
          REG_COUNT: count_cfg    <= cfg.data[COUNT_W-1:0];
          default:   ;
        endcase
      end

      // Drop the result once taken; S_DONE looks after the output register itself
      if (rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_addr   <= req.address;
            res_addr   <= '0;
            // Only an alloc can fail at once, on an empty list or before init
            res_status <= ((op_t'(req.operation) == OP_ALLOC) && alloc_fail) ? ST_EMPTY
                                                                              : ST_OK;
            case (op_t'(req.operation))
              OP_INIT:  state <= S_INIT_CHK;
              OP_ALLOC: state <= alloc_fail ? S_DONE : S_ALLOC_MUL;
              OP_FREE:  state <= S_FREE_CHK;
              default:  state <= S_DONE;
            endcase
          end
        end

        S_INIT_CHK: begin
          // Product count * rounded size is registered for the span check
          if (init_bad) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else begin
            state <= S_INIT_SPAN;
          end
        end

        S_INIT_SPAN: begin
          if (span_over) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else begin
            active_size  <= size_round;
            active_count <= count_cfg;
            active_span  <= prod[SPAN_W-1:0];
            sweep_idx    <= '0;
            state        <= S_INIT_FILL;
          end
        end

        S_INIT_FILL: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (fill_last) begin
            head        <= '0;
            used_blocks <= '0;
            pool_ready  <= 1'b1;
            state       <= S_DONE;
          end
        end

        S_ALLOC_MUL: begin
          // head * size is being registered
          state <= S_ALLOC_ADD;
        end

        S_ALLOC_ADD: begin
          res_addr <= base_address + ADDR_W'(prod);
          head     <= ram_rdata;
          if (used_blocks != UsedMax) begin
            used_blocks <= used_blocks + 1'b1;
          end
          state <= S_DONE;
        end

        S_FREE_CHK: begin
          if (free_bad) begin
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_DIV;
          end
        end

        S_FREE_DIV: begin
          if (div_done) begin
            if (div_rem != '0) begin
              res_status <= ST_REJECT;
            end else begin
              head <= LinkW'(div_quot);
              if (used_blocks != '0) begin
                used_blocks <= used_blocks - 1'b1;
              end
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_addr   <= res_addr;
            rsp_used   <= used_blocks;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg.ready         = 1'b1;
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.block_address = rsp_addr;
  assign rsp.blocks_in_use = rsp_used;

`ifndef SYNTHESIS
  // The divider only reports back while a free waits on it
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_FREE_DIV))
    else $error("divider finished outside a free");

  // An accepted item keeps the block busy in the following cycle
  assert property (@(posedge clk) disable iff (rst) (req.valid && req.ready) |=> !req.ready)
    else $error("item accepted while previous one still in flight");

  // A result appears only from the completion state
  assert property (@(posedge clk) disable iff (rst) $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside completion");

  // Head is a block index or the end-of-list mark
  assert property (@(posedge clk) disable iff (rst) 32'(head) <= 32'(NUM_BLOCKS))
    else $error("free list head out of range");
`endif

endmodule

`default_nettype wire

// ----- src/fbpa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/fbpa_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbpa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fbpa_pkg::SPAN_W-1:0]   dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [fbpa_pkg::COUNT_W-1:0]  quot,
  output logic [fbpa_pkg::SPAN_W-1:0]   rem
);
  import fbpa_pkg::*;

  localparam int StepW = $clog2(COUNT_W);

  logic              busy;
  logic [StepW-1:0]  step;
  logic [SPAN_W-1:0] dsh;
  logic [SPAN_W:0]   diff;

  // Restoring divide, one quotient bit a cycle; dividend < divisor << COUNT_W
  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend;
        dsh  <= SPAN_W'(divisor) << (COUNT_W - 1);
        quot <= '0;
        step <= StepW'(COUNT_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[SPAN_W]) begin
          rem <= diff[SPAN_W-1:0];
        end
        quot <= {quot[COUNT_W-2:0], ~diff[SPAN_W]};
        dsh  <= dsh >> 1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
